@@ rtl/tap_pkg.sv @@
// tap_pkg: shared types, constants and codes of the trapezoid angle profile.
// No dependencies; every other file of the block imports this package.
package tap_pkg;

    localparam int VW     = 32;       // value width, Q16.16
    localparam int FW     = 16;       // fraction bits
    localparam int DTW    = 16;       // step_time width, Q0.16
    localparam int RW     = 31;       // rate and speed width
    localparam int AW     = 5;        // APB address width
    localparam int PW     = 2 * RW;   // product width
    localparam int WRAP_W = 34;       // biased distance width
    localparam int REM_W  = 25;       // remainder width, holds 360 deg
    localparam int LEN_W  = 5;        // multiplier step count width
    localparam int CNT_W  = 6;        // wrap step count width

    localparam logic [REM_W-1:0]  DEG_FULL  = 25'd23592960;  // 360 deg
    localparam logic [REM_W-1:0]  DEG_HALF  = 25'd11796480;  // 180 deg
    localparam logic [REM_W-1:0]  DEG_SNAP  = 25'd196608;    // 3 deg
    // 183 turns: lifts any 33-bit difference above zero, keeps it mod 360
    localparam logic [WRAP_W-1:0] WRAP_BIAS = 34'd4317511680;

    localparam logic [LEN_W-1:0] LEN_VV = 5'd31;
    localparam logic [LEN_W-1:0] LEN_DD = 5'd26;
    localparam logic [LEN_W-1:0] LEN_DT = 5'd16;

    localparam logic [RW-1:0]  RST_MAXV  = 31'd23592960;
    localparam logic [RW-1:0]  RST_ACCEL = 31'd47185920;
    localparam logic [RW-1:0]  RST_DECEL = 31'd47185920;
    localparam logic [DTW-1:0] RST_DT    = 16'd655;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_GOAL = 2'd1,
        CMD_LOAD = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        REG_MODE  = 3'd0,
        REG_MAXV  = 3'd1,
        REG_ACCEL = 3'd2,
        REG_DECEL = 3'd3,
        REG_DT    = 3'd4
    } t_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRAP,
        S_MUL,
        S_PUSH
    } t_state;

    typedef enum logic [1:0] {
        PH_VV,   // v*v
        PH_DD,   // decel*2|d|
        PH_ST,   // rate*dt
        PH_MV    // speed*dt
    } t_phase;

    typedef struct packed {
        logic             start;
        logic [RW-1:0]    a;
        logic [RW-1:0]    b;
        logic [LEN_W-1:0] len;
    } t_mul_req;

    typedef struct packed {
        logic              start;
        logic [WRAP_W-1:0] x;
    } t_wrap_req;

endpackage

@@ rtl/tap_if.sv @@
// tap_in_if / tap_out_if: valid-ready channels of the profile block.
// Depends on tap_pkg for the field widths.
interface tap_in_if;
    import tap_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           command;
    logic signed [VW-1:0] value;
    modport source (output valid, command, value, input ready);
    modport sink   (input valid, command, value, output ready);
endinterface

interface tap_out_if;
    import tap_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] level;
    logic                 done_res;
    modport source (output valid, level, done_res, input ready);
    modport sink   (input valid, level, done_res, output ready);
endinterface

@@ rtl/tap_smul.sv @@
// tap_smul: bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on tap_pkg.
module tap_smul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tap_pkg::t_mul_req i_req,
    output logic              o_done,
    output logic [tap_pkg::PW-1:0] o_prod
);
    import tap_pkg::*;

    logic [PW-1:0]    r_ma;
    logic [RW-1:0]    r_mb;
    logic [PW-1:0]    r_acc;
    logic [LEN_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [PW-1:0]    n_acc;

    assign n_acc = r_mb[0] ? r_acc + r_ma : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == LEN_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma  <= {{(PW-RW){1'b0}}, i_req.a};
            r_mb  <= i_req.b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_ma  <= r_ma << 1;
            r_mb  <= r_mb >> 1;
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ rtl/tap_wrap.sv @@
// tap_wrap: serial restoring remainder modulo 360 degrees, one bit per cycle.
// Depends on tap_pkg.
module tap_wrap (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tap_pkg::t_wrap_req i_req,
    output logic               o_done,
    output logic [tap_pkg::REM_W-1:0] o_rem
);
    import tap_pkg::*;

    logic [WRAP_W-1:0] r_x;
    logic [REM_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W:0]    trial;
    logic [REM_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_x[WRAP_W-1]};
        if (trial >= {1'b0, DEG_FULL}) begin
            n_rem = REM_W'(trial - {1'b0, DEG_FULL});
        end else begin
            n_rem = trial[REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WRAP_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_req.x;
            r_rem <= '0;
        end else if (r_busy) begin
            r_x   <= r_x << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ rtl/trapezoid_angle_profile.sv @@
// trapezoid_angle_profile: trapezoidal setpoint generator, top level.
// Depends on tap_pkg, tap_if, tap_smul and tap_wrap.
//
// Usage:
//  - i_cmd carries one item {command, value}: tick, set target, or load
//    position and target. o_res returns one item {level, done_res} per input.
//  - APB port sets the mode, speed limit, acceleration, deceleration and
//    step time at byte addresses 0,4,8,12,16; write only while idle.
//  - Work runs through a bit-serial multiplier (one multiplier bit a cycle)
//    and a bit-serial modulo-360 unit; one item at a time.
//  - Flow: set/load, idle tick or unknown command go straight to the push
//    state. Speed-mode tick: one 16-bit rate*dt multiply. Angle-mode tick:
//    wrap, v*v, decel*2|d|, rate*dt (skipped when speed is held), speed*dt,
//    wrap; a zero first remainder ends it after the first wrap.
//  - Output register: a finished result waits in it while the next item
//    is already taken; if it is still full when the next result is ready,
//    the block holds in its push state until o_res.ready frees it.
//  - Reset (synchronous, active low): position, target, speed 0, done 1,
//    registers to their defaults, output empty.
module trapezoid_angle_profile (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tap_in_if.sink                i_cmd,
    tap_out_if.source             o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [tap_pkg::AW-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import tap_pkg::*;

    // configuration
    logic            r_mode;
    logic [RW-1:0]   r_maxv;
    logic [RW-1:0]   r_accel;
    logic [RW-1:0]   r_decel;
    logic [DTW-1:0]  r_dt;
    logic            cfg_wr;
    t_reg            cfg_idx;

    // profile state
    t_state               r_state, n_state;
    t_phase               r_phase, n_phase;
    logic signed [VW-1:0] r_pos, n_pos;
    logic signed [VW-1:0] r_goal, n_goal;
    logic [RW-1:0]        r_speed, n_speed;
    logic                 r_fin, n_fin;
    logic                 r_second, n_second;  // second wrap = snap check
    logic                 r_neg, n_neg;        // shortest direction negative
    logic                 r_slow, n_slow;      // decelerate / ramp down
    logic [REM_W-1:0]     r_ad, n_ad;
    logic [PW-1:0]        r_vv, n_vv;

    // result register
    logic                 r_oval, n_oval;
    logic signed [VW-1:0] r_level;
    logic                 r_odone;
    logic                 load_out;

    // units
    t_mul_req          mul_req;
    t_wrap_req         wrap_req;
    logic              mul_done, wrap_done;
    logic [PW-1:0]     prod;
    logic [REM_W-1:0]  w_rem;

    // helpers
    logic                 in_acc, out_free, tick_run;
    logic                 w_neg;
    logic [REM_W-1:0]     w_abs;
    logic [RW-1:0]        stp;
    logic [RW-1:0]        sp_dec, sp_acc, sp_new;
    logic [RW:0]          sp_sum;
    logic signed [VW:0]   pos_x, goal_x, pos_up, pos_dn, pos_mv;
    logic signed [VW-1:0] pos_sat;
    logic                 slow_sel;

    function automatic logic [WRAP_W-1:0] wrap_arg(input logic signed [VW-1:0] g,
                                                   input logic signed [VW-1:0] p);
        return {{(WRAP_W-VW){g[VW-1]}}, g} - {{(WRAP_W-VW){p[VW-1]}}, p} + WRAP_BIAS;
    endfunction

    tap_smul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    tap_wrap u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (wrap_req),
        .o_done  (wrap_done),
        .o_rem   (w_rem)
    );

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = t_reg'(paddr[AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_maxv  <= RST_MAXV;
            r_accel <= RST_ACCEL;
            r_decel <= RST_DECEL;
            r_dt    <= RST_DT;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MODE:  r_mode  <= pwdata[0];
                REG_MAXV:  r_maxv  <= pwdata[RW-1:0];
                REG_ACCEL: r_accel <= pwdata[RW-1:0];
                REG_DECEL: r_decel <= pwdata[RW-1:0];
                REG_DT:    r_dt    <= pwdata[DTW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MODE:  prdata = {31'd0, r_mode};
            REG_MAXV:  prdata = {1'b0, r_maxv};
            REG_ACCEL: prdata = {1'b0, r_accel};
            REG_DECEL: prdata = {1'b0, r_decel};
            REG_DT:    prdata = {16'd0, r_dt};
            default:   prdata = '0;
        endcase
    end

    // ---------------- shared helper terms ----------------
    assign i_cmd.ready = (r_state == S_IDLE);
    assign in_acc      = i_cmd.valid & i_cmd.ready;
    assign out_free    = !r_oval || o_res.ready;
    assign tick_run    = in_acc && (i_cmd.command == CMD_TICK) && !r_fin &&
                         (!r_mode || (r_pos != r_goal));

    // wrapped distance in (-180,180]: negative when remainder above 180
    assign w_neg = (w_rem > DEG_HALF);
    assign w_abs = w_neg ? DEG_FULL - w_rem : w_rem;

    // (x * dt) >> FW
    assign stp = prod[FW+RW-1:FW];

    assign sp_dec = (r_speed > stp) ? r_speed - stp : '0;
    assign sp_sum = {1'b0, r_speed} + {1'b0, stp};
    assign sp_acc = (sp_sum > {1'b0, r_maxv}) ? r_maxv : sp_sum[RW-1:0];
    assign sp_new = r_slow ? sp_dec : sp_acc;

    assign pos_x  = {r_pos[VW-1], r_pos};
    assign goal_x = {r_goal[VW-1], r_goal};
    assign pos_up = pos_x + $signed({2'b00, stp});
    assign pos_dn = pos_x - $signed({2'b00, stp});
    assign pos_mv = r_neg ? pos_dn : pos_up;

    always_comb begin
        if (pos_mv[VW] != pos_mv[VW-1]) begin
            pos_sat = pos_mv[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
            pos_sat = pos_mv[VW-1:0];
        end
    end

    // deceleration test: v^2 >= 2*decel*|d|
    assign slow_sel = (r_vv >= prod);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (tick_run) begin
                        n_state = r_mode ? S_MUL : S_WRAP;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_WRAP: begin
                if (wrap_done) begin
                    n_state = (!r_second && (w_rem != '0)) ? S_MUL : S_PUSH;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    if (r_phase == PH_ST && r_mode) begin
                        n_state = S_PUSH;
                    end else if (r_phase == PH_MV) begin
                        n_state = S_WRAP;
                    end
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- datapath and unit control ----------------
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_goal   = r_goal;
        n_speed  = r_speed;
        n_fin    = r_fin;
        n_second = r_second;
        n_neg    = r_neg;
        n_slow   = r_slow;
        n_ad     = r_ad;
        n_vv     = r_vv;
        load_out = 1'b0;
        mul_req  = '{start: 1'b0, a: r_speed, b: {{(RW-DTW){1'b0}}, r_dt}, len: LEN_DT};
        wrap_req = '{start: 1'b0, x: wrap_arg(r_goal, r_pos)};

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_cmd.command)
                        CMD_TICK: begin
                            if (tick_run) begin
                                if (r_mode) begin
                                    n_slow        = !(r_pos < r_goal);
                                    n_neg         = n_slow;
                                    n_phase       = PH_ST;
                                    mul_req.start = 1'b1;
                                    mul_req.a     = n_slow ? r_decel : r_accel;
                                end else begin
                                    n_second       = 1'b0;
                                    wrap_req.start = 1'b1;
                                end
                            end else if (r_mode && !r_fin) begin
                                n_fin = 1'b1;   // already at target
                            end
                        end
                        CMD_GOAL: begin
                            n_goal = i_cmd.value;
                            n_fin  = 1'b0;
                        end
                        CMD_LOAD: begin
                            n_pos   = i_cmd.value;
                            n_goal  = i_cmd.value;
                            n_speed = '0;
                            n_fin   = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_WRAP: begin
                if (wrap_done) begin
                    if (!r_second) begin
                        if (w_rem == '0) begin
                            n_speed = '0;
                            n_fin   = 1'b1;
                        end else begin
                            n_neg         = w_neg;
                            n_ad          = w_abs;
                            n_phase       = PH_VV;
                            mul_req.start = 1'b1;
                            mul_req.a     = r_speed;
                            mul_req.b     = r_speed;
                            mul_req.len   = LEN_VV;
                        end
                    end else if ((r_speed == '0) && (w_abs < DEG_SNAP)) begin
                        n_pos = r_goal;
                        n_fin = 1'b1;
                    end
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    case (r_phase)
                        PH_VV: begin
                            n_vv          = prod;
                            n_phase       = PH_DD;
                            mul_req.start = 1'b1;
                            mul_req.a     = r_decel;
                            mul_req.b     = {{(RW-REM_W-1){1'b0}}, r_ad, 1'b0};
                            mul_req.len   = LEN_DD;
                        end
                        PH_DD: begin
                            mul_req.start = 1'b1;
                            n_slow        = slow_sel;
                            if (slow_sel) begin
                                n_phase   = PH_ST;
                                mul_req.a = r_decel;
                            end else if (r_speed < r_maxv) begin
                                n_phase   = PH_ST;
                                mul_req.a = r_accel;
                            end else begin
                                n_phase   = PH_MV;   // speed held
                                mul_req.a = r_speed;
                            end
                        end
                        PH_ST: begin
                            if (r_mode) begin
                                // ramp toward target, clamp there
                                if (!r_slow) begin
                                    if (pos_up >= goal_x) begin
                                        n_pos = r_goal;
                                        n_fin = 1'b1;
                                    end else begin
                                        n_pos = pos_up[VW-1:0];
                                    end
                                end else begin
                                    if (pos_dn <= goal_x) begin
                                        n_pos = r_goal;
                                        n_fin = 1'b1;
                                    end else begin
                                        n_pos = pos_dn[VW-1:0];
                                    end
                                end
                            end else begin
                                n_speed       = sp_new;
                                n_phase       = PH_MV;
                                mul_req.start = 1'b1;
                                mul_req.a     = sp_new;
                            end
                        end
                        PH_MV: begin
                            n_pos          = pos_sat;
                            n_second       = 1'b1;
                            wrap_req.start = 1'b1;
                            wrap_req.x     = wrap_arg(r_goal, pos_sat);
                        end
                        default: ;
                    endcase
                end
            end
            S_PUSH: begin
                load_out = out_free;
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_VV;
            r_pos    <= '0;
            r_goal   <= '0;
            r_speed  <= '0;
            r_fin    <= 1'b1;
            r_second <= 1'b0;
            r_oval   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_goal   <= n_goal;
            r_speed  <= n_speed;
            r_fin    <= n_fin;
            r_second <= n_second;
            r_oval   <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_slow <= n_slow;
        r_ad   <= n_ad;
        r_vv   <= n_vv;
        if (load_out) begin
            r_level <= r_pos;
            r_odone <= r_fin;
        end
    end

    always_comb begin
        if (load_out) begin
            n_oval = 1'b1;
        end else if (o_res.ready) begin
            n_oval = 1'b0;
        end else begin
            n_oval = r_oval;
        end
    end

    assign o_res.valid    = r_oval;
    assign o_res.level    = r_level;
    assign o_res.done_res = r_odone;

    // ---------------- assertions ----------------
    a_wrap_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wrap_done |-> (r_state == S_WRAP))
        else $error("wrap unit finished outside its wait state");

    a_mul_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL))
        else $error("multiplier finished outside its wait state");

    a_load_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_cmd.command == CMD_LOAD)) |=> (r_pos == $past(i_cmd.value)) && r_fin)
        else $error("load command did not set position");

    a_goal_clears_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_cmd.command == CMD_GOAL)) |=> !r_fin)
        else $error("set target did not clear done");

endmodule

@@ test/tap_checker.sv @@
`timescale 1ns / 100ps
// tap_checker: watches the command, result and APB channels of the profile
// block, predicts every result and compares. Depends on tap_pkg and tap_if.
module tap_checker
    import tap_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tap_in_if                     i_cmd,
    tap_out_if                    i_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [AW-1:0]         paddr,
    input  logic [31:0]           pwdata,
    output int                    o_fail,
    output int                    o_pending
);

    typedef struct packed {
        logic [VW-1:0] level;
        logic          done_res;
    } t_level;

    localparam longint ONE_DEG  = 64'sd65536;
    localparam longint FULL_TURN = 360 * ONE_DEG;
    localparam longint HALF_TURN = 180 * ONE_DEG;
    localparam longint SNAP_DIST = 3 * ONE_DEG;
    localparam longint VAL_MAX   = 64'sd2147483647;
    localparam longint VAL_MIN   = -64'sd2147483648;

    // mirrored registers
    logic            mode_q;
    longint          maxv_q, accel_q, decel_q, dt_q;
    // mirrored profile state
    longint          pos_q, goal_q, speed_q;
    logic            fin_q;

    t_level          level_fifo[$];
    int              fail_cnt;

    assign o_fail    = fail_cnt;
    assign o_pending = level_fifo.size();

    function automatic longint clamp_val(longint x);
        if (x > VAL_MAX) return VAL_MAX;
        if (x < VAL_MIN) return VAL_MIN;
        return x;
    endfunction

    function automatic longint wrap_deg(longint d);
        longint r;
        r = d % FULL_TURN;
        if (r < 0) r += FULL_TURN;
        if (r > HALF_TURN) r -= FULL_TURN;
        return r;
    endfunction

    // rate * dt in Q0.16, truncated
    function automatic longint scale_dt(longint rate);
        return (rate * dt_q) >>> 16;
    endfunction

    task automatic angle_step();
        longint      d, ad, mv, chk, st;
        logic [127:0] vv, dd;
        d = wrap_deg(goal_q - pos_q);
        if (d == 0) begin
            speed_q = 0;
            fin_q   = 1'b1;
            return;
        end
        ad = (d < 0) ? -d : d;
        vv = 128'(speed_q) * 128'(speed_q);
        dd = 128'(decel_q) * 128'(ad * 2);
        if (vv >= dd) begin
            st = scale_dt(decel_q);
            speed_q = (speed_q > st) ? speed_q - st : 0;
        end else if (speed_q < maxv_q) begin
            speed_q += scale_dt(accel_q);
            if (speed_q > maxv_q) speed_q = maxv_q;
        end
        mv = scale_dt(speed_q);
        pos_q = (d > 0) ? clamp_val(pos_q + mv) : clamp_val(pos_q - mv);
        chk = wrap_deg(goal_q - pos_q);
        if (chk < 0) chk = -chk;
        // stopped close to the target: snap onto it
        if (speed_q == 0 && chk < SNAP_DIST) begin
            pos_q = goal_q;
            fin_q = 1'b1;
        end
    endtask

    task automatic ramp_step();
        if (pos_q < goal_q) begin
            pos_q += scale_dt(accel_q);
            if (pos_q >= goal_q) begin
                pos_q = goal_q;
                fin_q = 1'b1;
            end
        end else if (pos_q > goal_q) begin
            pos_q -= scale_dt(decel_q);
            if (pos_q <= goal_q) begin
                pos_q = goal_q;
                fin_q = 1'b1;
            end
        end else begin
            fin_q = 1'b1;
        end
    endtask

    task automatic predict_item(logic [1:0] cmd, logic signed [VW-1:0] val);
        longint v;
        t_level lv;
        v = longint'(val);
        case (cmd)
            CMD_TICK: if (!fin_q) begin
                if (mode_q) ramp_step();
                else angle_step();
            end
            CMD_GOAL: begin
                goal_q = v;
                fin_q  = 1'b0;
            end
            CMD_LOAD: begin
                pos_q   = v;
                goal_q  = v;
                speed_q = 0;
                fin_q   = 1'b1;
            end
            default: ;  // unused code leaves state alone
        endcase
        lv.level    = pos_q[VW-1:0];
        lv.done_res = fin_q;
        level_fifo.push_back(lv);
    endtask

    always @(posedge i_clk) begin
        t_level want;
        if (!i_rst_n) begin
            mode_q  = 1'b0;
            maxv_q  = RST_MAXV;
            accel_q = RST_ACCEL;
            decel_q = RST_DECEL;
            dt_q    = RST_DT;
            pos_q   = 0;
            goal_q  = 0;
            speed_q = 0;
            fin_q   = 1'b1;
            level_fifo.delete();
            fail_cnt = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[AW-1:2])
                    REG_MODE:  mode_q  = pwdata[0];
                    REG_MAXV:  maxv_q  = pwdata[RW-1:0];
                    REG_ACCEL: accel_q = pwdata[RW-1:0];
                    REG_DECEL: decel_q = pwdata[RW-1:0];
                    REG_DT:    dt_q    = pwdata[DTW-1:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (level_fifo.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected result level=%h done=%b", $time,
                             i_res.level, i_res.done_res);
                end else begin
                    want = level_fifo.pop_front();
                    if (want.level !== i_res.level || want.done_res !== i_res.done_res) begin
                        fail_cnt++;
                        $display("%0t: mismatch expected level=%h done=%b, got level=%h done=%b",
                                 $time, want.level, want.done_res, i_res.level,
                                 i_res.done_res);
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) predict_item(i_cmd.command, i_cmd.value);
        end
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for trapezoid_angle_profile.
// Depends on tap_pkg, tap_if, the block's RTL and tap_checker.
module tb_top;
    import tap_pkg::*;

    logic          i_clk;
    logic          i_rst_n;
    logic          psel, penable, pwrite;
    logic [AW-1:0] paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    int            fail_cnt, pending;
    bit            no_gaps;     // set for stretches without idling

    tap_in_if  cmd_ch ();
    tap_out_if res_ch ();

    trapezoid_angle_profile i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tap_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_ch),
        .i_res     (res_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .o_fail    (fail_cnt),
        .o_pending (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // generous bound for the angle ticks plus long stalls
    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    // mostly zero or short, now and then long
    function automatic int gap_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: random back-pressure
    initial begin
        int g;
        res_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            g = gap_len();
            if (g > 0) begin
                res_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(res_ch.valid && res_ch.ready)) @(posedge i_clk);
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [31:0] val);
        int g;
        g = gap_len();
        if (g > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.value   <= val;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
    endtask

    // drain: valid low, wait for all results, let the block settle
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_profile(logic mode, logic [30:0] maxv, logic [30:0] acc,
                               logic [30:0] dec, logic [15:0] dt);
        drain();
        apb_write(REG_MODE, {31'd0, mode});
        apb_write(REG_MAXV, {1'b0, maxv});
        apb_write(REG_ACCEL, {1'b0, acc});
        apb_write(REG_DECEL, {1'b0, dec});
        apb_write(REG_DT, {16'd0, dt});
    endtask

    // random rate: extremes now and then, usually a range that converges
    function automatic logic [30:0] pick_rate(int lo_deg, int hi_deg);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 31'h7fffffff;
        if (r == 1) return 31'd1;
        return 31'($urandom_range(lo_deg, hi_deg)) << 16 | 31'($urandom_range(0, 65535));
    endfunction

    // mostly angles within +-720 deg, some full-range values
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 1440)) - 720) << 16 | 32'($urandom_range(0, 65535));
    endfunction

    initial begin
        int          n, r, k;
        logic        mode;
        logic [1:0]  cmd;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= CMD_TICK;
        cmd_ch.value   <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        no_gaps = 1'b0;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, extremes of value, each command, unused code
        send_item(CMD_TICK, 32'h0);              // idle tick
        send_item(CMD_LOAD, 32'h7fffffff);
        send_item(CMD_GOAL, 32'h80000000);       // wrap across the extremes
        repeat (4) send_item(CMD_TICK, 32'hffffffff);
        send_item(2'd3, 32'h12345678);           // unused code
        send_item(CMD_LOAD, 32'h80000000);
        send_item(CMD_GOAL, 32'h80000000);       // zero distance
        send_item(CMD_TICK, 32'h0);
        send_item(CMD_LOAD, 32'h0);
        send_item(CMD_GOAL, 32'h00020000);       // within snap distance
        repeat (3) send_item(CMD_TICK, 32'h0);
        // all rates at their maximum: huge steps saturate
        set_profile(1'b0, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 16'hffff);
        send_item(CMD_GOAL, 32'h00b40000);       // exactly 180 deg
        repeat (3) send_item(CMD_TICK, 32'h0);
        // minimum rates, zero step time: stalls
        set_profile(1'b0, 31'd0, 31'd1, 31'd1, 16'd0);
        send_item(CMD_GOAL, 32'hff000000);
        repeat (2) send_item(CMD_TICK, 32'h0);
        // speed mode at the extremes
        set_profile(1'b1, 31'h7fffffff, 31'h7fffffff, 31'd1, 16'hffff);
        send_item(CMD_GOAL, 32'h7fffffff);
        repeat (2) send_item(CMD_TICK, 32'h0);

        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            mode = $urandom_range(0, 2) == 0;
            set_profile(mode, pick_rate(30, 2000), pick_rate(50, 5000),
                        pick_rate(50, 5000), 16'($urandom_range(300, 20000)));
            no_gaps = (ph % 4) == 3;
            n = 0;
            while (n < 92) begin
                r = $urandom_range(0, 99);
                if (r < 14) begin
                    // well-formed move: new target, then a run of ticks
                    send_item(CMD_GOAL, pick_value());
                    k = $urandom_range(5, 40);
                    repeat (k) send_item(CMD_TICK, $urandom);
                    n += k + 1;
                end else if (r < 18) begin
                    send_item(CMD_LOAD, pick_value());
                    n++;
                end else if (r < 21) begin
                    send_item(2'd3, $urandom);
                    n++;
                end else if (r < 24) begin
                    cmd = 2'($urandom_range(0, 3));
                    send_item(cmd, $urandom);
                    n++;
                end else begin
                    send_item(CMD_TICK, $urandom);
                    n++;
                end
                // sender holds off until every result is back
                if (ph == 5 && n > 50 && n < 60) drain();
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
